// ===== sv/dsmf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsmf_pkg - shared types and constants of the dual sliding median filter
// Window depth, row width, beat structs and the window vector type.
// ----------------------------------------------------------------------------
package dsmf_pkg;

	// window depth and row width
	localparam int WINDOW    = 9;
	localparam int ROW_BITS  = 12;
	localparam int RANK_BITS = $clog2(WINDOW);
	localparam int FILL_BITS = $clog2(WINDOW + 1);

	typedef logic [ROW_BITS-1:0] row_t;
	typedef row_t [WINDOW-1:0] win_t;

	// input beat: one pair of detected rows
	typedef struct packed {
		row_t upper_row;
		row_t lower_row;
	} row_beat_t;

	// output beat: medians of both windows
	typedef struct packed {
		row_t upper_median;
		row_t lower_median;
	} median_beat_t;

endpackage

// ===== sv/dual_sliding_median_filter_unit.sv =====
// ----------------------------------------------------------------------------
// dual_sliding_median_filter_unit - median of the last WINDOW row pairs
// Keeps two sliding windows and emits both medians per full-window beat.
// ----------------------------------------------------------------------------
//  channel   direction  payload          handshake
//  row       in         row_beat_t       row_valid / row_ready
//  median    out        median_beat_t    median_valid / median_ready
//
//  One row beat per cycle is accepted while row_ready is high; the first
//  WINDOW beats only fill the windows. Each later beat yields one median beat
//  via the window register, then the rank-select network into the output
//  register. Reset clears the fill count and the valid flags; window contents
//  are not cleared. A stalled output holds one result while one more waits in
//  the window stage; row_ready drops only when both are occupied.
// ----------------------------------------------------------------------------
module dual_sliding_median_filter_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   row_valid,
	output logic                   row_ready,
	input  dsmf_pkg::row_beat_t    row,
	output logic                   median_valid,
	input  logic                   median_ready,
	output dsmf_pkg::median_beat_t median
);
	import dsmf_pkg::*;

	logic         row_acc;
	logic         win_full;
	win_t         upper_win;
	win_t         lower_win;
	row_t         upper_med;
	row_t         lower_med;
	logic         pend_s1;
	logic         adv;
	logic         out_valid_q;
	median_beat_t out_q;

	// handshake: window stage moves when the output register frees up
	assign adv       = pend_s1 && (!out_valid_q || median_ready);
	assign row_ready = !pend_s1 || adv;
	assign row_acc   = row_valid && row_ready;

	dsmf_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (row_acc),
		.beat      (row),
		.full      (win_full),
		.upper_win (upper_win),
		.lower_win (lower_win)
	);

	dsmf_median u_upper_med (
		.win    (upper_win),
		.median (upper_med)
	);

	dsmf_median u_lower_med (
		.win    (lower_win),
		.median (lower_med)
	);

	// window stage holds a snapshot awaiting median select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (row_acc) begin
			pend_s1 <= win_full;
		end else if (adv) begin
			pend_s1 <= 1'b0;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (median_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.upper_median <= upper_med;
			out_q.lower_median <= lower_med;
		end
	end

	assign median_valid = out_valid_q;
	assign median       = out_q;

endmodule

// ===== sv/dsmf_window.sv =====
// ----------------------------------------------------------------------------
// dsmf_window - sample windows for both row positions
// Two shift lines of WINDOW entries plus a saturating fill counter.
// ----------------------------------------------------------------------------
module dsmf_window (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dsmf_pkg::row_beat_t beat,
	output logic              full,
	output dsmf_pkg::win_t    upper_win,
	output dsmf_pkg::win_t    lower_win
);
	import dsmf_pkg::*;

	win_t                 upper_q;
	win_t                 lower_q;
	logic [FILL_BITS-1:0] fill_q;

	assign full      = (fill_q == FILL_BITS'(WINDOW));
	assign upper_win = upper_q;
	assign lower_win = lower_q;

	// fill counter, saturates at the window depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push && !full) begin
			fill_q <= fill_q + FILL_BITS'(1);
		end
	end

	// shift lines: entry 0 is the oldest, new sample enters at the top
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				upper_q[i] <= upper_q[i+1];
				lower_q[i] <= lower_q[i+1];
			end
			upper_q[WINDOW-1] <= beat.upper_row;
			lower_q[WINDOW-1] <= beat.lower_row;
		end
	end

endmodule

// ===== sv/dsmf_median.sv =====
// ----------------------------------------------------------------------------
// dsmf_median - median select over one window
// Rank counting: every entry is compared with all others in parallel, ties
// broken by position, and the entry of middle rank is selected.
// ----------------------------------------------------------------------------
module dsmf_median (
	input  dsmf_pkg::win_t win,
	output dsmf_pkg::row_t median
);
	import dsmf_pkg::*;

	localparam logic [RANK_BITS-1:0] MID = RANK_BITS'(WINDOW / 2);

	logic [RANK_BITS-1:0] rank [WINDOW];

	// rank of each entry: smaller entries, plus equal ones placed earlier
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if ((win[j] < win[i]) || ((j < i) && (win[j] == win[i]))) begin
					rank[i] = rank[i] + RANK_BITS'(1);
				end
			end
		end
	end

	// ranks form a permutation, so exactly one entry matches
	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (rank[i] == MID) begin
				median = median | win[i];
			end
		end
	end

endmodule

// ===== sv/dsmf_checker.sv =====
// ----------------------------------------------------------------------------
// dsmf_checker - port-level checks of the median filter
// Tracks fill and outstanding results from the handshakes alone.
// ----------------------------------------------------------------------------
module dsmf_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   row_valid,
	input logic                   row_ready,
	input logic                   median_valid,
	input logic                   median_ready,
	input dsmf_pkg::median_beat_t median
);
	import dsmf_pkg::*;

	logic                 row_acc;
	logic                 med_acc;
	logic                 full_acc;
	logic [FILL_BITS-1:0] fill_q;
	logic [2:0]           owed_q;

	assign row_acc  = row_valid && row_ready;
	assign med_acc  = median_valid && median_ready;
	assign full_acc = row_acc && (fill_q == FILL_BITS'(WINDOW));

	// accepted beats until the windows are full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (row_acc && (fill_q != FILL_BITS'(WINDOW))) begin
			fill_q <= fill_q + FILL_BITS'(1);
		end
	end

	// results owed: full-window beats in minus median beats out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else begin
			owed_q <= owed_q + {2'b00, full_acc} - {2'b00, med_acc};
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		median_valid && !median_ready |=> median_valid && $stable(median))
		else $error("median beat changed while stalled");

	// no result without a full-window beat owed
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		median_valid |-> owed_q != 3'd0)
		else $error("median beat without a matching row beat");

	// at most two results in flight
	a_owed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q <= 3'd2)
		else $error("too many results in flight");

	// both stages occupied and output stalled: input must back off
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(owed_q == 3'd2) && !median_ready |-> !row_ready)
		else $error("row beat taken with no room left");

endmodule

bind dual_sliding_median_filter_unit dsmf_checker u_dsmf_checker (.*);
